// ===== hdl/qapm_pkg.sv =====
`timescale 1ns / 1ps

package qapm_pkg;

    // Stream payload widths
    localparam int IN_W      = 136;
    localparam int OUT_W     = 64;

    // Configuration port
    localparam int CFG_NUM   = 6;
    localparam int CFG_IDX_W = 3;
    localparam int K_W       = 24;

    // Shared multiply-accumulate unit
    localparam int OPA_W     = 25;
    localparam int OPB_W     = 22;
    localparam int PROD_W    = OPA_W + OPB_W;
    localparam int ACC_W     = 67;
    localparam int AXIS_W    = 62;

    // Stick handling
    localparam logic signed [12:0] STICK_CTR   = 13'sd1500;
    localparam logic signed [12:0] THR_IDLE    = 13'sd1000;
    localparam logic [11:0]        THR_ACTIVE  = 12'd1200;
    localparam logic [11:0]        YAW_DB_LO   = 12'd1400;
    localparam logic [11:0]        YAW_DB_HI   = 12'd1600;
    // 2622 / 2^16 is 1/25 closely enough for magnitudes below 4096
    localparam logic signed [OPA_W-1:0] RECIP_25 = 25'sd2622;

    // Limits
    localparam logic signed [19:0] INT_LIM = 20'sd256000;
    localparam logic signed [22:0] HD_LIM  = 23'sd1310720;
    localparam logic signed [ACC_W-1:0] ACC_CAP = 67'sh1000_0000_0000_0000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RP_KP  = 3'd0,
        REG_RP_KI  = 3'd1,
        REG_RP_KD  = 3'd2,
        REG_YAW_KP = 3'd3,
        REG_YAW_KI = 3'd4,
        REG_YAW_KD = 3'd5
    } qapm_reg_t;

    localparam logic [K_W-1:0] CFG_RESET [CFG_NUM] = '{
        24'd353894, 24'd328, 24'd4456, 24'd524288, 24'd3932, 24'd5898
    };

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_DIVR,
        ST_DIVP,
        ST_YDQ,
        ST_RKP,
        ST_RKI,
        ST_RKD,
        ST_PKP,
        ST_PKI,
        ST_PKD,
        ST_YLO,
        ST_YHI,
        ST_YHIC,
        ST_YCAP,
        ST_YKP,
        ST_YDQA,
        ST_MBASE,
        ST_MR,
        ST_MP,
        ST_MY,
        ST_DONE
    } qapm_state_t;

    typedef enum logic [1:0] {
        SH_0,
        SH_9,
        SH_16,
        SH_21
    } qapm_shift_t;

    typedef struct packed {
        logic        acc_en;
        logic        clr;
        logic        neg;
        logic        cap;
        logic        ext;
        qapm_shift_t sh;
    } qapm_ctrl_t;

    // Clamp a roll or pitch integrator sum to +-2000 degrees in Q9.7
    function automatic logic signed [18:0] clamp_int(input logic signed [19:0] v);
        logic signed [19:0] r;
        begin
            if (v > INT_LIM)
            begin
                r = INT_LIM;
            end
            else if (v < -INT_LIM)
            begin
                r = -INT_LIM;
            end
            else
            begin
                r = v;
            end
            return r[18:0];
        end
    endfunction

    // Clamp the heading accumulator to +-20 in Q5.16
    function automatic logic signed [21:0] clamp_hd(input logic signed [22:0] v);
        logic signed [22:0] r;
        begin
            if (v > HD_LIM)
            begin
                r = HD_LIM;
            end
            else if (v < -HD_LIM)
            begin
                r = -HD_LIM;
            end
            else
            begin
                r = v;
            end
            return r[21:0];
        end
    endfunction

    // Cap the yaw cross product at magnitude 2^60
    function automatic logic signed [ACC_W-1:0] cap_acc(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] r;
        begin
            if (v > ACC_CAP)
            begin
                r = ACC_CAP;
            end
            else if (v < -ACC_CAP)
            begin
                r = -ACC_CAP;
            end
            else
            begin
                r = v;
            end
            return r;
        end
    endfunction

    // Drop 32 fraction bits toward zero, then saturate to int16
    function automatic logic signed [15:0] sat_motor(input logic signed [ACC_W-1:0] v);
        logic signed [35:0] q;
        logic signed [15:0] r;
        begin
            q = 36'($signed(v[ACC_W-1:32]))
                + (((v[ACC_W-1] == 1'b1) && (v[31:0] != 32'd0)) ? 36'sd1 : 36'sd0);
            if (q > 36'sd32767)
            begin
                r = 16'sh7fff;
            end
            else if (q < -36'sd32768)
            begin
                r = 16'sh8000;
            end
            else
            begin
                r = q[15:0];
            end
            return r;
        end
    endfunction

    // X-frame mix: bit 0 roll, bit 1 pitch, bit 2 yaw; a set bit subtracts
    function automatic logic [2:0] mix_sign(input logic [1:0] idx);
        logic [2:0] s;
        begin
            case (idx)
                2'd0:    s = 3'b000;
                2'd1:    s = 3'b110;
                2'd2:    s = 3'b011;
                2'd3:    s = 3'b101;
                default: s = 3'b000;
            endcase
            return s;
        end
    endfunction

endpackage

// ===== hdl/quad_attitude_pid_mixer_top.sv =====
`timescale 1ns / 1ps
// Input requests are taken only while the sequencer is idle, so a new request waits until
//   the last one is finished; one shared 25x22 multiplier with a
//   67-bit accumulator does every product and sum, stepped by the sequencer.
// A finished result waits in the output register while the next request is taken.
// Reset (rst_n low, asynchronous): sequencer idle, output empty, integrators and
//   heading cleared, gain registers back to their default values.

module quad_attitude_pid_mixer_top
    import qapm_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // att_roll[15:0], att_pitch[31:16], gyro_x[47:32], gyro_y[63:48], gyro_z[79:64],
    // stick_roll[91:80], stick_pitch[103:92], stick_yaw[115:104],
    // stick_throttle[127:116], armed[128], zero fill[135:129]
    input  logic [IN_W-1:0]      s_axis_tdata,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // motor_1[15:0], motor_2[31:16], motor_3[47:32], motor_4[63:48]
    output logic [OUT_W-1:0]     m_axis_tdata,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [K_W-1:0]       cfg_data
);

    // Sequencer
    qapm_state_t state_reg;
    qapm_state_t state_next;
    logic [1:0]  mot_idx_reg;

    // Gain registers
    logic [K_W-1:0] cfg_reg [CFG_NUM];

    // Captured request
    logic signed [15:0] att_roll_reg;
    logic signed [15:0] att_pitch_reg;
    logic signed [15:0] gyro_x_reg;
    logic signed [15:0] gyro_y_reg;
    logic signed [17:0] gz_reg;
    logic [11:0]        mag_r_reg;
    logic [11:0]        mag_p_reg;
    logic               neg_r_reg;
    logic               neg_p_reg;
    logic [11:0]        thr_reg;
    logic               low_reg;
    logic               mot_en_reg;

    // Working values
    logic signed [16:0]       er_reg;
    logic signed [16:0]       ep_reg;
    logic signed [20:0]       inc_reg;
    logic signed [41:0]       ydq_reg;
    logic signed [AXIS_W-1:0] r_reg;
    logic signed [AXIS_W-1:0] p_reg;
    logic signed [AXIS_W-1:0] y_reg;
    logic signed [15:0]       m_reg [3];

    // Controller state
    logic signed [18:0] ri_reg;
    logic signed [18:0] pi_reg;
    logic signed [21:0] hd_reg;

    // Output register
    logic [OUT_W-1:0] out_data_reg;
    logic             out_valid_reg;

    // Request field decode
    logic signed [15:0] in_att_roll;
    logic signed [15:0] in_att_pitch;
    logic signed [15:0] in_gyro_x;
    logic signed [15:0] in_gyro_y;
    logic signed [15:0] in_gyro_z;
    logic [11:0]        in_stick_roll;
    logic [11:0]        in_stick_pitch;
    logic [11:0]        in_stick_yaw;
    logic [11:0]        in_stick_thr;
    logic               in_armed;
    logic signed [12:0] d_r;
    logic signed [12:0] d_p;
    logic signed [12:0] d_y;
    logic               yaw_dead;
    logic signed [17:0] gz_in;
    logic               accept;

    // Shared unit hookup
    logic signed [OPA_W-1:0]  op_a;
    logic signed [OPB_W-1:0]  op_b;
    logic signed [ACC_W-1:0]  ext_term;
    qapm_ctrl_t               ctrl;
    logic signed [PROD_W-1:0] prod;
    logic signed [ACC_W-1:0]  acc;
    logic signed [ACC_W-1:0]  acc_sum;

    // Per-step helpers
    logic [6:0]         quot;
    logic signed [16:0] off17;
    logic signed [27:0] gz28;
    logic signed [27:0] inc_full;
    logic signed [12:0] thr_base;
    logic [2:0]         sgn;
    logic               out_free;

    assign in_att_roll    = s_axis_tdata[15:0];
    assign in_att_pitch   = s_axis_tdata[31:16];
    assign in_gyro_x      = s_axis_tdata[47:32];
    assign in_gyro_y      = s_axis_tdata[63:48];
    assign in_gyro_z      = s_axis_tdata[79:64];
    assign in_stick_roll  = s_axis_tdata[91:80];
    assign in_stick_pitch = s_axis_tdata[103:92];
    assign in_stick_yaw   = s_axis_tdata[115:104];
    assign in_stick_thr   = s_axis_tdata[127:116];
    assign in_armed       = s_axis_tdata[128];

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !out_valid_reg || m_axis_tready;

    // Stick offsets around center; the yaw stick only counts outside its deadband
    assign d_r      = $signed({1'b0, in_stick_roll}) - STICK_CTR;
    assign d_p      = $signed({1'b0, in_stick_pitch}) - STICK_CTR;
    assign d_y      = $signed({1'b0, in_stick_yaw}) - STICK_CTR;
    assign yaw_dead = (in_stick_yaw >= YAW_DB_LO) && (in_stick_yaw <= YAW_DB_HI);
    assign gz_in    = 18'(in_gyro_z) + (yaw_dead ? 18'sd0 : (18'(d_y) <<< 1));

    // Quotient of |stick - 1500| / 25 out of the reciprocal product
    assign quot  = prod[22:16];
    assign off17 = $signed({3'b000, quot, 7'b0000000});

    // Heading increment: gz * 1023 / 128, rounded half up
    assign gz28     = 28'(gz_reg);
    assign inc_full = (gz28 <<< 10) - gz28 + 28'sd64;

    assign thr_base = $signed({1'b0, thr_reg}) - THR_IDLE;
    assign sgn      = mix_sign(mot_idx_reg);

    qapm_mac u_mac (
        .clk      (clk),
        .op_a     (op_a),
        .op_b     (op_b),
        .ext_term (ext_term),
        .ctrl     (ctrl),
        .prod     (prod),
        .acc      (acc),
        .acc_sum  (acc_sum)
    );

    // Sequencer: a step may issue a product and may fold an earlier product or an external term in
    always_comb
    begin
        state_next = state_reg;
        op_a       = '0;
        op_b       = '0;
        ext_term   = '0;
        ctrl       = '{acc_en: 1'b0, clr: 1'b0, neg: 1'b0, cap: 1'b0, ext: 1'b0, sh: SH_0};
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_DIVR;
                end
            end
            ST_DIVR:
            begin
                op_a       = RECIP_25;
                op_b       = {10'b0, mag_r_reg};
                state_next = ST_DIVP;
            end
            ST_DIVP:
            begin
                op_a       = RECIP_25;
                op_b       = {10'b0, mag_p_reg};
                state_next = ST_YDQ;
            end
            ST_YDQ:
            begin
                op_a       = {1'b0, cfg_reg[REG_YAW_KD]};
                op_b       = OPB_W'(gz_reg);
                state_next = ST_RKP;
            end
            ST_RKP:
            begin
                op_a       = {1'b0, cfg_reg[REG_RP_KP]};
                op_b       = OPB_W'(er_reg);
                state_next = ST_RKI;
            end
            ST_RKI:
            begin
                op_a       = {1'b0, cfg_reg[REG_RP_KI]};
                op_b       = OPB_W'(ri_reg);
                ctrl       = '{acc_en: 1'b1, clr: 1'b1, neg: 1'b1, cap: 1'b0, ext: 1'b0,
                               sh: SH_9};
                state_next = ST_RKD;
            end
            ST_RKD:
            begin
                op_a       = {1'b0, cfg_reg[REG_RP_KD]};
                op_b       = OPB_W'(gyro_y_reg);
                ctrl       = '{acc_en: 1'b1, clr: 1'b0, neg: 1'b1, cap: 1'b0, ext: 1'b0,
                               sh: SH_9};
                state_next = ST_PKP;
            end
            ST_PKP:
            begin
                op_a       = {1'b0, cfg_reg[REG_RP_KP]};
                op_b       = OPB_W'(ep_reg);
                ctrl       = '{acc_en: 1'b1, clr: 1'b0, neg: 1'b1, cap: 1'b0, ext: 1'b0,
                               sh: SH_16};
                state_next = ST_PKI;
            end
            ST_PKI:
            begin
                op_a       = {1'b0, cfg_reg[REG_RP_KI]};
                op_b       = OPB_W'(pi_reg);
                ctrl       = '{acc_en: 1'b1, clr: 1'b1, neg: 1'b0, cap: 1'b0, ext: 1'b0,
                               sh: SH_9};
                state_next = ST_PKD;
            end
            ST_PKD:
            begin
                op_a       = {1'b0, cfg_reg[REG_RP_KD]};
                op_b       = OPB_W'(gyro_x_reg);
                ctrl       = '{acc_en: 1'b1, clr: 1'b0, neg: 1'b0, cap: 1'b0, ext: 1'b0,
                               sh: SH_9};
                state_next = ST_YLO;
            end
            ST_YLO:
            begin
                op_a       = {1'b0, cfg_reg[REG_YAW_KI]};
                op_b       = {1'b0, ydq_reg[20:0]};
                ctrl       = '{acc_en: 1'b1, clr: 1'b0, neg: 1'b0, cap: 1'b0, ext: 1'b0,
                               sh: SH_16};
                state_next = ST_YHI;
            end
            ST_YHI:
            begin
                op_a       = {1'b0, cfg_reg[REG_YAW_KI]};
                op_b       = OPB_W'($signed(ydq_reg[41:21]));
                ctrl       = '{acc_en: 1'b1, clr: 1'b1, neg: 1'b0, cap: 1'b0, ext: 1'b0,
                               sh: SH_0};
                state_next = ST_YHIC;
            end
            ST_YHIC:
            begin
                ctrl       = '{acc_en: 1'b1, clr: 1'b0, neg: 1'b0, cap: 1'b0, ext: 1'b0,
                               sh: SH_21};
                state_next = ST_YCAP;
            end
            ST_YCAP:
            begin
                op_a       = {1'b0, cfg_reg[REG_YAW_KP]};
                op_b       = hd_reg;
                ctrl       = '{acc_en: 1'b1, clr: 1'b0, neg: 1'b0, cap: 1'b1, ext: 1'b0,
                               sh: SH_0};
                state_next = ST_YKP;
            end
            ST_YKP:
            begin
                ctrl       = '{acc_en: 1'b1, clr: 1'b0, neg: 1'b0, cap: 1'b0, ext: 1'b0,
                               sh: SH_0};
                state_next = ST_YDQA;
            end
            ST_YDQA:
            begin
                ext_term   = ACC_W'(ydq_reg) <<< 16;
                ctrl       = '{acc_en: 1'b1, clr: 1'b0, neg: 1'b0, cap: 1'b0, ext: 1'b1,
                               sh: SH_0};
                state_next = ST_MBASE;
            end
            ST_MBASE:
            begin
                ext_term   = ACC_W'(thr_base) <<< 32;
                ctrl       = '{acc_en: 1'b1, clr: 1'b1, neg: 1'b0, cap: 1'b0, ext: 1'b1,
                               sh: SH_0};
                state_next = ST_MR;
            end
            ST_MR:
            begin
                ext_term   = ACC_W'(r_reg);
                ctrl       = '{acc_en: 1'b1, clr: 1'b0, neg: sgn[0], cap: 1'b0, ext: 1'b1,
                               sh: SH_0};
                state_next = ST_MP;
            end
            ST_MP:
            begin
                ext_term   = ACC_W'(p_reg);
                ctrl       = '{acc_en: 1'b1, clr: 1'b0, neg: sgn[1], cap: 1'b0, ext: 1'b1,
                               sh: SH_0};
                state_next = ST_MY;
            end
            ST_MY:
            begin
                ext_term   = ACC_W'(y_reg);
                ctrl       = '{acc_en: 1'b1, clr: 1'b0, neg: sgn[2], cap: 1'b0, ext: 1'b1,
                               sh: SH_0};
                state_next = (mot_idx_reg == 2'd3) ? ST_DONE : ST_MBASE;
            end
            ST_DONE:
            begin
                // Hold until the output register can take the result
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Gain registers; writes beyond the list are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CFG_NUM; i++)
            begin
                cfg_reg[i] <= CFG_RESET[i];
            end
        end
        else if (cfg_wr_en && (cfg_index < CFG_IDX_W'(CFG_NUM)))
        begin
            cfg_reg[cfg_index] <= cfg_data;
        end
    end

    // Integrators, heading, motor index and output handshake
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ri_reg        <= '0;
            pi_reg        <= '0;
            hd_reg        <= '0;
            mot_idx_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // Low throttle clears each integrator after its error is formed
            if (state_reg == ST_DIVP)
            begin
                hd_reg <= low_reg ? '0 : clamp_hd(23'(hd_reg) + 23'(inc_reg));
            end
            if (state_reg == ST_YDQ)
            begin
                ri_reg <= low_reg ? '0 : clamp_int(20'(ri_reg) + 20'(er_reg));
            end
            if (state_reg == ST_RKP)
            begin
                pi_reg <= low_reg ? '0 : clamp_int(20'(pi_reg) + 20'(ep_reg));
            end
            if (state_reg == ST_MY)
            begin
                mot_idx_reg <= mot_idx_reg + 2'd1;
            end
            if ((state_reg == ST_DONE) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            att_roll_reg  <= in_att_roll;
            att_pitch_reg <= in_att_pitch;
            gyro_x_reg    <= in_gyro_x;
            gyro_y_reg    <= in_gyro_y;
            gz_reg        <= gz_in;
            neg_r_reg     <= d_r[12];
            neg_p_reg     <= d_p[12];
            mag_r_reg     <= d_r[12] ? 12'(-d_r) : d_r[11:0];
            mag_p_reg     <= d_p[12] ? 12'(-d_p) : d_p[11:0];
            thr_reg       <= in_stick_thr;
            low_reg       <= (in_stick_thr < THR_ACTIVE);
            mot_en_reg    <= (in_stick_thr > THR_ACTIVE) && in_armed;
        end
        case (state_reg)
            ST_DIVR:
            begin
                inc_reg <= inc_full[27:7];
            end
            ST_DIVP:
            begin
                // Roll takes the stick offset off, pitch adds it
                er_reg <= neg_r_reg ? (17'(att_roll_reg) + off17)
                                    : (17'(att_roll_reg) - off17);
            end
            ST_YDQ:
            begin
                ep_reg <= neg_p_reg ? (17'(att_pitch_reg) - off17)
                                    : (17'(att_pitch_reg) + off17);
            end
            ST_RKP:
            begin
                ydq_reg <= prod[41:0];
            end
            ST_PKP:
            begin
                r_reg <= acc_sum[AXIS_W-1:0];
            end
            ST_YLO:
            begin
                p_reg <= acc_sum[AXIS_W-1:0];
            end
            ST_YDQA:
            begin
                y_reg <= acc_sum[AXIS_W-1:0];
            end
            ST_MBASE:
            begin
                // Retire the motor summed in the previous pass
                if (mot_idx_reg != 2'd0)
                begin
                    m_reg[mot_idx_reg - 2'd1] <= sat_motor(acc);
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_data_reg <= mot_en_reg ? {sat_motor(acc), m_reg[2], m_reg[1], m_reg[0]}
                                               : '0;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // Checks
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ST_DIVR))
        else $error("request accepted but sequencer did not start");

    a_roll_int_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (20'(ri_reg) <= INT_LIM) && (20'(ri_reg) >= -INT_LIM))
        else $error("roll integrator beyond limit");

    a_pitch_int_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (20'(pi_reg) <= INT_LIM) && (20'(pi_reg) >= -INT_LIM))
        else $error("pitch integrator beyond limit");

    a_heading_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (23'(hd_reg) <= HD_LIM) && (23'(hd_reg) >= -HD_LIM))
        else $error("heading beyond limit");

    a_idle_index: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (mot_idx_reg == 2'd0))
        else $error("motor index not rewound at idle");

    a_disarmed_zero: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_DONE) && out_free && !mot_en_reg) |=> (m_axis_tdata == '0))
        else $error("motors not zero while disabled");

endmodule

// ===== hdl/qapm_mac.sv =====
`timescale 1ns / 1ps

module qapm_mac
    import qapm_pkg::*;
(
    input  logic                     clk,
    input  logic signed [OPA_W-1:0]  op_a,
    input  logic signed [OPB_W-1:0]  op_b,
    input  logic signed [ACC_W-1:0]  ext_term,
    input  qapm_ctrl_t               ctrl,
    output logic signed [PROD_W-1:0] prod,
    output logic signed [ACC_W-1:0]  acc,
    output logic signed [ACC_W-1:0]  acc_sum
);

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  prod_ext;
    logic signed [ACC_W-1:0]  shifted;
    logic signed [ACC_W-1:0]  term;
    logic signed [ACC_W-1:0]  base;

    assign prod_next = op_a * op_b;

    always_comb
    begin
        prod_ext = ACC_W'(prod_reg);
        case (ctrl.sh)
            SH_0:    shifted = prod_ext;
            SH_9:    shifted = prod_ext <<< 9;
            SH_16:   shifted = prod_ext <<< 16;
            SH_21:   shifted = prod_ext <<< 21;
            default: shifted = prod_ext;
        endcase
        term    = ctrl.ext ? ext_term : shifted;
        base    = ctrl.clr ? '0 : acc_reg;
        acc_sum = ctrl.neg ? (base - term) : (base + term);
    end

    // Product register always advances; accumulator only when enabled
    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        if (ctrl.acc_en)
        begin
            acc_reg <= ctrl.cap ? cap_acc(acc_reg) : acc_sum;
        end
    end

    assign prod = prod_reg;
    assign acc  = acc_reg;

endmodule

// ===== verif/qapm_tb_pkg.sv =====
`timescale 1ns / 1ps

package qapm_tb_pkg;

    import qapm_pkg::*;

    // One control tick as it sits on s_axis_tdata (last member in the lowest bits)
    typedef struct packed {
        logic [6:0]         fill;
        logic               armed;
        logic [11:0]        stick_throttle;
        logic [11:0]        stick_yaw;
        logic [11:0]        stick_pitch;
        logic [11:0]        stick_roll;
        logic signed [15:0] gyro_z;
        logic signed [15:0] gyro_y;
        logic signed [15:0] gyro_x;
        logic signed [15:0] att_pitch;
        logic signed [15:0] att_roll;
    } tick_t;

    // Four motor commands as they sit on m_axis_tdata
    typedef struct packed {
        logic signed [15:0] motor_4;
        logic signed [15:0] motor_3;
        logic signed [15:0] motor_2;
        logic signed [15:0] motor_1;
    } motors_t;

    localparam logic [K_W-1:0] GAIN_AT_RESET [CFG_NUM] = '{
        24'd353894, 24'd328, 24'd4456, 24'd524288, 24'd3932, 24'd5898
    };

    // Stick and throttle landmarks in microseconds
    localparam longint STICK_MID   = 1500;
    localparam longint STICK_STEP  = 25;
    localparam longint THR_LIVE    = 1200;
    localparam longint THR_BASE    = 1000;
    localparam longint YAW_DEAD_LO = 1400;
    localparam longint YAW_DEAD_HI = 1600;

    // 2000 degrees in Q9.7 and 20 in Q5.16
    localparam longint ANGLE_SUM_MAX = 256000;
    localparam longint HEADING_MAX   = 1310720;
    localparam longint YAW_RATE_MUL  = 1023;

endpackage

// ===== verif/qapm_motor_checker.sv =====
`timescale 1ns / 1ps

module qapm_motor_checker
    import qapm_pkg::*;
    import qapm_tb_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    input  logic                 s_axis_tready,
    input  logic [IN_W-1:0]      s_axis_tdata,
    input  logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    input  logic [OUT_W-1:0]     m_axis_tdata,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [K_W-1:0]       cfg_data,
    output int                   mismatches,
    output int                   motors_owed
);

    localparam longint      ONE_Q32   = 64'sd4294967296;
    localparam logic [63:0] CROSS_CAP = 64'd1 << 60;

    logic [K_W-1:0] gain [CFG_NUM];
    longint         roll_err_sum;
    longint         pitch_err_sum;
    longint         heading_acc;
    motors_t        motors_due [$];

    initial
    begin
        mismatches  = 0;
        motors_owed = 0;
    end

    task automatic report_mismatch(input string what);
        $display("%0t qapm mismatch: %s", $time, what);
        mismatches++;
    endtask

    function automatic longint clip(input longint v, input longint lim);
        if (v > lim)
        begin
            return lim;
        end
        if (v < -lim)
        begin
            return -lim;
        end
        return v;
    endfunction

    // Drop 32 fraction bits toward zero, then saturate to int16
    function automatic logic signed [15:0] to_motor(input longint sum);
        longint q;
        q = sum / ONE_Q32;
        if (q > 32767)
        begin
            q = 32767;
        end
        else if (q < -32768)
        begin
            q = -32768;
        end
        return 16'(q);
    endfunction

    // Advance the integrators by one tick and form the four motor commands
    function automatic motors_t predict_motors(input tick_t t);
        longint      sr, sp, sy, thr, er, ep, gz, roll, pitch, yaw, ydq, cross_term, base;
        longint      kp, ki, kd, ykp, ykd;
        logic [63:0] mag, prod;
        logic        low;
        motors_t     m;
        sr   = t.stick_roll;
        sp   = t.stick_pitch;
        sy   = t.stick_yaw;
        thr  = t.stick_throttle;
        kp   = gain[REG_RP_KP];
        ki   = gain[REG_RP_KI];
        kd   = gain[REG_RP_KD];
        ykp  = gain[REG_YAW_KP];
        ykd  = gain[REG_YAW_KD];
        low  = (thr < THR_LIVE);

        er = longint'(t.att_roll) - ((sr - STICK_MID) / STICK_STEP) * 128;
        ep = longint'(t.att_pitch) + ((sp - STICK_MID) / STICK_STEP) * 128;
        roll_err_sum  = low ? 0 : clip(roll_err_sum + er, ANGLE_SUM_MAX);
        pitch_err_sum = low ? 0 : clip(pitch_err_sum + ep, ANGLE_SUM_MAX);

        // Stick outside the deadband adds to the rate at full width
        gz = t.gyro_z;
        if (sy < YAW_DEAD_LO || sy > YAW_DEAD_HI)
        begin
            gz = gz + (sy - STICK_MID) * 2;
        end
        if (low)
        begin
            heading_acc = 0;
        end
        else
        begin
            heading_acc = clip(heading_acc + ((gz * YAW_RATE_MUL + 64) >>> 7), HEADING_MAX);
        end

        roll  = -(kp * er * 512) - (ki * roll_err_sum * 512) - (kd * longint'(t.gyro_y) * 65536);
        pitch = (kp * ep * 512) + (ki * pitch_err_sum * 512) + (kd * longint'(t.gyro_x) * 65536);

        // Cross product of the two yaw rate gains, magnitude capped
        ydq  = ykd * gz;
        mag  = (ydq < 0) ? 64'(-ydq) : 64'(ydq);
        prod = mag * {40'd0, gain[REG_YAW_KI]};
        if (prod > CROSS_CAP)
        begin
            prod = CROSS_CAP;
        end
        cross_term = (ydq < 0) ? -longint'(prod) : longint'(prod);
        yaw        = ykp * heading_acc + cross_term + ydq * 65536;

        m = '0;
        if (thr > THR_LIVE && t.armed)
        begin
            base      = (thr - THR_BASE) * ONE_Q32;
            m.motor_1 = to_motor(base + roll + pitch + yaw);
            m.motor_2 = to_motor(base + roll - pitch - yaw);
            m.motor_3 = to_motor(base - roll - pitch + yaw);
            m.motor_4 = to_motor(base - roll + pitch - yaw);
        end
        return m;
    endfunction

    task automatic check_motor(input string name, input logic signed [15:0] got,
                               input logic signed [15:0] want);
        if (got !== want)
        begin
            report_mismatch($sformatf("%s got %0d, expected %0d", name, got, want));
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        motors_t got;
        motors_t want;
        if (!rst_n)
        begin
            gain          = GAIN_AT_RESET;
            roll_err_sum  = 0;
            pitch_err_sum = 0;
            heading_acc   = 0;
            motors_due.delete();
            motors_owed   = 0;
        end
        else
        begin
            if (cfg_wr_en && cfg_index < CFG_NUM)
            begin
                gain[cfg_index] = cfg_data;
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                motors_due.push_back(predict_motors(tick_t'(s_axis_tdata)));
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = motors_t'(m_axis_tdata);
                if (motors_due.size() == 0)
                begin
                    report_mismatch($sformatf("unrequested result %h", m_axis_tdata));
                end
                else
                begin
                    want = motors_due.pop_front();
                    check_motor("motor_1", got.motor_1, want.motor_1);
                    check_motor("motor_2", got.motor_2, want.motor_2);
                    check_motor("motor_3", got.motor_3, want.motor_3);
                    check_motor("motor_4", got.motor_4, want.motor_4);
                end
            end
            motors_owed = motors_due.size();
        end
    end

endmodule

// ===== verif/quad_attitude_pid_mixer_top_test.sv =====
`timescale 1ns / 1ps

module quad_attitude_pid_mixer_top_test;

    import qapm_pkg::*;
    import qapm_tb_pkg::*;

    // Hard stop on the cycle count
    localparam int RUN_LIMIT = 400000;
    // Index past the last gain register: the block must ignore it
    localparam logic [CFG_IDX_W-1:0] REG_NONE = CFG_IDX_W'(CFG_NUM);

    logic                 clk;
    logic                 rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    // att_roll, att_pitch, gyro_x, gyro_y, gyro_z, stick_roll, stick_pitch,
    // stick_yaw, stick_throttle, armed, zero fill (lowest bit up)
    logic [IN_W-1:0]      s_axis_tdata;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    // motor_1, motor_2, motor_3, motor_4 (lowest bit up)
    logic [OUT_W-1:0]     m_axis_tdata;
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [K_W-1:0]       cfg_data;

    int                   mismatches;
    int                   motors_owed;
    int                   cycles;
    bit                   steady_flow;   // no idling on either side while set
    int                   rx_hold;       // receiver hold-off request, in cycles
    logic [K_W-1:0]       gains [CFG_NUM];

    quad_attitude_pid_mixer_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    qapm_motor_checker checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .mismatches    (mismatches),
        .motors_owed   (motors_owed)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // Abort a hung run
    initial
    begin
        cycles = 0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == RUN_LIMIT)
        begin
            $display("[quad_attitude_pid_mixer_top] ERROR");
            $finish;
        end
    end

    // Result side: stall at random before taking each result. A hold-off request
    // from the stimulus keeps tready low for a long stretch, counted here, so the
    // output register fills and the block has to refuse input requests.
    initial
    begin
        int stall;
        int hold;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (rx_hold > 0)
            begin
                hold    = rx_hold;
                rx_hold = 0;
                m_axis_tready <= 1'b0;
                repeat (hold) @(negedge clk);
            end
            stall = steady_flow ? 0 : $urandom_range(0, 5);
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_axis_tready <= 1'b1;
            // Hold tready until a result is taken
            do
            begin
                @(posedge clk);
            end
            while (!m_axis_tvalid);
        end
    end

    function automatic logic signed [15:0] rand_s16(input int span);
        int v;
        v = int'($urandom_range(0, 2 * span)) - span;
        return 16'(v);
    endfunction

    function automatic tick_t make_tick(input int ar, input int ap, input int gx,
                                        input int gy, input int gz, input int sr,
                                        input int sp, input int sy, input int thr,
                                        input int arm);
        tick_t t;
        t                = '0;
        t.att_roll       = 16'(ar);
        t.att_pitch      = 16'(ap);
        t.gyro_x         = 16'(gx);
        t.gyro_y         = 16'(gy);
        t.gyro_z         = 16'(gz);
        t.stick_roll     = 12'(sr);
        t.stick_pitch    = 12'(sp);
        t.stick_yaw      = 12'(sy);
        t.stick_throttle = 12'(thr);
        t.armed          = arm[0];
        return t;
    endfunction

    // Plausible flight tick: modest angles and rates, sticks around center,
    // throttle mostly live with occasional dips around the integrator cutoff
    function automatic tick_t flight_tick();
        tick_t t;
        int    span;
        t              = '0;
        span           = ($urandom_range(0, 7) == 0) ? 32767 : 5760;
        t.att_roll     = rand_s16(span);
        t.att_pitch    = rand_s16(span);
        t.gyro_x       = rand_s16(3000);
        t.gyro_y       = rand_s16(3000);
        t.gyro_z       = rand_s16(3000);
        t.stick_roll   = 12'($urandom_range(1000, 2000));
        t.stick_pitch  = 12'($urandom_range(1000, 2000));
        t.stick_yaw    = 12'($urandom_range(1200, 1800));
        if ($urandom_range(0, 15) == 0)
        begin
            t.stick_throttle = 12'($urandom_range(1150, 1250));
        end
        else
        begin
            t.stick_throttle = 12'($urandom_range(1201, 2000));
        end
        t.armed = ($urandom_range(0, 9) != 0);
        return t;
    endfunction

    // Every field across its whole range
    function automatic tick_t noise_tick();
        tick_t t;
        t                = '0;
        t.att_roll       = 16'($urandom);
        t.att_pitch      = 16'($urandom);
        t.gyro_x         = 16'($urandom);
        t.gyro_y         = 16'($urandom);
        t.gyro_z         = 16'($urandom);
        t.stick_roll     = 12'($urandom);
        t.stick_pitch    = 12'($urandom);
        t.stick_yaw      = 12'($urandom);
        t.stick_throttle = 12'($urandom);
        t.armed          = 1'($urandom);
        return t;
    endfunction

    // Offer one tick and hold it until the block takes the request.
    // Called and returns at a falling edge.
    task automatic send_tick(input tick_t t);
        int gap;
        gap = steady_flow ? 0 : $urandom_range(0, 5);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tdata  <= t;
        s_axis_tvalid <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!s_axis_tready);
        @(negedge clk);
    endtask

    // Drop valid and wait until every result owed has been taken
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (motors_owed != 0)
        begin
            @(negedge clk);
        end
        repeat (4) @(negedge clk);
    endtask

    // Write all gain registers in one burst, then a stray index the block must ignore
    task automatic load_gains();
        for (int i = 0; i < CFG_NUM; i++)
        begin
            cfg_wr_en <= 1'b1;
            cfg_index <= qapm_reg_t'(i);
            cfg_data  <= gains[i];
            @(negedge clk);
        end
        cfg_index <= REG_NONE;
        cfg_data  <= K_W'($urandom);
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        @(negedge clk);
    endtask

    // Mostly flight runs with random content; some runs are pure noise and
    // a few stray noise ticks break up the flight runs
    task automatic random_ticks(input int count);
        int left;
        int run;
        bit noisy;
        left = count;
        while (left > 0)
        begin
            run   = $urandom_range(4, 40);
            noisy = ($urandom_range(0, 9) == 0);
            if (run > left)
            begin
                run = left;
            end
            repeat (run)
            begin
                if (noisy || $urandom_range(0, 19) == 0)
                begin
                    send_tick(noise_tick());
                end
                else
                begin
                    send_tick(flight_tick());
                end
            end
            left -= run;
        end
    endtask

    initial
    begin
        steady_flow   = 1'b0;
        rx_hold       = 0;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        cfg_wr_en     = 1'b0;
        cfg_index     = REG_RP_KP;
        cfg_data      = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed ticks at the default gains
        send_tick(make_tick(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_tick(make_tick(0, 0, 0, 0, 0, 1500, 1500, 1500, 1500, 1));
        // Throttle at the cutoff: integrate but motors off
        send_tick(make_tick(640, -640, 100, -100, 50, 1500, 1500, 1500, 1200, 1));
        // Just below: integrators clear
        send_tick(make_tick(640, -640, 100, -100, 50, 1500, 1500, 1500, 1199, 1));
        send_tick(make_tick(640, -640, 100, -100, 50, 1500, 1500, 1500, 1201, 1));
        // Live throttle but disarmed
        send_tick(make_tick(640, -640, 100, -100, 50, 1500, 1500, 1500, 1800, 0));
        // Stick offsets on either side of a whole degree
        send_tick(make_tick(0, 0, 0, 0, 0, 1476, 1524, 1500, 1500, 1));
        send_tick(make_tick(0, 0, 0, 0, 0, 1475, 1525, 1500, 1500, 1));
        // Yaw deadband edges
        send_tick(make_tick(0, 0, 0, 0, 0, 1500, 1500, 1399, 1500, 1));
        send_tick(make_tick(0, 0, 0, 0, 0, 1500, 1500, 1400, 1500, 1));
        send_tick(make_tick(0, 0, 0, 0, 0, 1500, 1500, 1600, 1500, 1));
        send_tick(make_tick(0, 0, 0, 0, 0, 1500, 1500, 1601, 1500, 1));
        // Field extremes; repeat to drive the integrators and heading into their clamps
        repeat (6)
        begin
            send_tick(make_tick(32767, -32768, 32767, -32768, 32767, 0, 4095, 4095, 4095, 1));
        end
        repeat (6)
        begin
            send_tick(make_tick(-32768, 32767, -32768, 32767, -32768, 4095, 0, 0, 4095, 1));
        end
        send_tick(make_tick(-1, -1, -1, -1, -1, 4095, 4095, 4095, 4095, 1));
        send_tick(make_tick(0, 0, 0, 0, 0, 1500, 1500, 1500, 0, 1));
        random_ticks(280);

        // Long receiver hold-off with the sender never idling: input must back up
        steady_flow = 1'b1;
        rx_hold     = 400;
        random_ticks(12);
        steady_flow = 1'b0;
        drain();

        // Every gain at full scale: saturation and the capped yaw cross product
        foreach (gains[i])
        begin
            gains[i] = '1;
        end
        load_gains();
        random_ticks(150);
        drain();

        // Every gain zero: motors follow throttle alone
        foreach (gains[i])
        begin
            gains[i] = '0;
        end
        load_gains();
        random_ticks(100);
        drain();

        // Full-range random gains, twice
        repeat (2)
        begin
            foreach (gains[i])
            begin
                gains[i] = K_W'($urandom);
            end
            load_gains();
            random_ticks(180);
            drain();
        end

        // Small random gains keep the motors mostly off the rails
        foreach (gains[i])
        begin
            gains[i] = K_W'($urandom_range(0, 1 << 18));
        end
        gains[REG_YAW_KP] = K_W'($urandom_range(0, 1 << 12));
        load_gains();
        random_ticks(150);
        drain();

        // Back to the defaults: a stretch with no idling, then idling again
        gains = GAIN_AT_RESET;
        load_gains();
        steady_flow = 1'b1;
        random_ticks(80);
        steady_flow = 1'b0;
        random_ticks(80);
        drain();

        // Allow the block's latency for any stray result to show up
        repeat (40) @(negedge clk);
        if (mismatches == 0 && motors_owed == 0)
        begin
            $display("[quad_attitude_pid_mixer_top] OK");
        end
        else
        begin
            $display("[quad_attitude_pid_mixer_top] ERROR");
        end
        $finish;
    end

endmodule
